FILE: hdl/srr_pkg.sv
// Shared types and constants for the selective repeat receiver.
package srr_pkg;

  localparam int WINDOW      = 10;
  localparam int MAX_PAYLOAD = 1024;
  localparam int QDEPTH      = 2;

  localparam int SEQ_W  = 16;
  localparam int LEN_W  = 11;
  localparam int SLOT_W = 4;
  localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  localparam logic [2:0] K_ACK      = 3'd0;
  localparam logic [2:0] K_NAK      = 3'd1;
  localparam logic [2:0] K_DIR      = 3'd2;
  localparam logic [2:0] K_FILENAME = 3'd3;
  localparam logic [2:0] K_DATA     = 3'd4;
  localparam logic [2:0] K_EOF      = 3'd5;
  localparam logic [2:0] K_EMPTY_FN = 3'd6;

  localparam logic [1:0] ST_IN_ORDER     = 2'd0;
  localparam logic [1:0] ST_OUT_OF_ORDER = 2'd1;
  localparam logic [1:0] ST_IGNORED      = 2'd2;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic             ok;
    logic [15:0]      reply_csum;
    logic [LEN_W-1:0] sat_len;
  } cmd_t;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } back_state_t;

endpackage

FILE: hdl/selective_repeat_receiver.sv
// Selective repeat receiver top level: front end, command queue, back end.
// A header is taken when start is high and busy is low. Each header first
// gives one ack or nak; an in-order ack is followed by the packets it
// releases, one per cycle, with no gaps, and last marks the final result of
// the transaction. Results are shown for one cycle under strobe and cannot be
// stalled. A header passes from the front end register into the command
// queue; the back end then gives its ack/nak and one result per released
// packet (up to WINDOW), the release walk visiting one window slot per
// cycle. A two-entry queue lets the front end keep taking headers while a
// walk runs; busy rises only when the queue and the front register are
// both full.
module selective_repeat_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] seq_num,
  input  logic [15:0] ack_field,
  input  logic [15:0] pkt_length,
  input  logic [15:0] checksum_received,
  input  logic [17:0] payload_sum,
  output logic        strobe,
  output logic [2:0]  kind,
  output logic [15:0] out_seq,
  output logic [10:0] out_length,
  output logic [3:0]  slot,
  output logic [1:0]  arrival_status,
  output logic [15:0] reply_checksum,
  output logic        last
);
  import srr_pkg::*;

  cmd_t front_cmd;
  cmd_t head;
  logic push;
  logic full;
  logic pop;
  logic not_empty;

  srr_front u_front (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .seq_num           (seq_num),
    .ack_field         (ack_field),
    .pkt_length        (pkt_length),
    .checksum_received (checksum_received),
    .payload_sum       (payload_sum),
    .push              (push),
    .full              (full),
    .cmd               (front_cmd)
  );

  srr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (front_cmd),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  srr_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (not_empty),
    .cmd            (head),
    .pop            (pop),
    .strobe         (strobe),
    .kind           (kind),
    .out_seq        (out_seq),
    .out_length     (out_length),
    .slot           (slot),
    .arrival_status (arrival_status),
    .reply_checksum (reply_checksum),
    .last           (last)
  );

endmodule

FILE: hdl/srr_front.sv
// Header capture, checksum check, reply checksum generation and length saturation.
module srr_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [15:0]          seq_num,
  input  logic [15:0]          ack_field,
  input  logic [15:0]          pkt_length,
  input  logic [15:0]          checksum_received,
  input  logic [17:0]          payload_sum,
  output logic                 push,
  input  logic                 full,
  output srr_pkg::cmd_t        cmd
);
  import srr_pkg::*;

  logic        valid;
  logic [15:0] seq_r;
  logic [15:0] ack_r;
  logic [15:0] len_r;
  logic [15:0] csum_r;
  logic [17:0] psum_r;
  logic [18:0] total;
  logic        accept;

  function automatic logic [15:0] fold16(input logic [18:0] s);
    logic [16:0] a;
    a = 17'(s[15:0]) + 17'(s[18:16]);
    return a[15:0] + 16'(a[16]);
  endfunction

  assign busy   = valid && full;
  assign accept = start && !busy;
  assign push   = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (valid && !full) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      seq_r  <= seq_num;
      ack_r  <= ack_field;
      len_r  <= pkt_length;
      csum_r <= checksum_received;
      psum_r <= payload_sum;
    end
  end

  always_comb begin
    total   = 19'(seq_r) + 19'(ack_r) + 19'(len_r) + 19'(psum_r);
    cmd.seq = seq_r;
    cmd.ok  = (~fold16(total)) == csum_r;
    if (cmd.ok) begin
      cmd.reply_csum = ~fold16(19'(seq_r) + 19'd1);
    end else begin
      cmd.reply_csum = ~fold16(19'(seq_r) + 19'd2);
    end
    if (32'(len_r) > MAX_PAYLOAD) begin
      cmd.sat_len = LEN_W'(MAX_PAYLOAD);
    end else begin
      cmd.sat_len = LEN_W'(len_r);
    end
  end

endmodule

FILE: hdl/srr_queue.sv
// Short command queue between the header front end and the release back end.
module srr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  srr_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output srr_pkg::cmd_t head
);
  import srr_pkg::*;

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full      = count == (QPTR_W+1)'(QDEPTH);
  assign not_empty = count != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

FILE: hdl/srr_back.sv
// Window buffer, ack/nak generation and in-order release walk.
module srr_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  input  srr_pkg::cmd_t             cmd,
  output logic                      pop,
  output logic                      strobe,
  output logic [2:0]                kind,
  output logic [srr_pkg::SEQ_W-1:0] out_seq,
  output logic [srr_pkg::LEN_W-1:0] out_length,
  output logic [srr_pkg::SLOT_W-1:0] slot,
  output logic [1:0]                arrival_status,
  output logic [15:0]               reply_checksum,
  output logic                      last
);
  import srr_pkg::*;

  back_state_t      state;
  back_state_t      state_next;
  logic [SEQ_W-1:0] exp;
  logic [IDX_W-1:0] exp_slot;
  logic             filled [WINDOW];
  logic [LEN_W-1:0] slen   [WINDOW];
  logic             dir_seen;
  logic             fn_seen;
  logic             done;

  logic             in_win;
  logic [SEQ_W-1:0] diff;
  logic [IDX_W:0]   slot_sum;
  logic [IDX_W-1:0] ins_slot;
  logic [IDX_W-1:0] nslot;
  logic             next_filled;
  logic [LEN_W-1:0] cur_len;
  logic             is_dir;
  logic             is_fn;

  logic              emit;
  logic [2:0]        k;
  logic [SEQ_W-1:0]  o_seq;
  logic [LEN_W-1:0]  o_len;
  logic [SLOT_W-1:0] o_slot;
  logic [1:0]        o_status;
  logic [15:0]       o_csum;
  logic              o_last;
  logic              ins_we;
  logic              advance;
  logic              set_dir;
  logic              set_fn;
  logic              set_done;

  always_comb begin
    in_win = !done && (cmd.seq >= exp) &&
             ((SEQ_W+1)'(cmd.seq) < (SEQ_W+1)'(exp) + (SEQ_W+1)'(WINDOW));
    diff     = cmd.seq - exp;
    slot_sum = (IDX_W+1)'(exp_slot) + (IDX_W+1)'(diff[IDX_W-1:0]);
    if (slot_sum >= (IDX_W+1)'(WINDOW)) begin
      ins_slot = IDX_W'(slot_sum - (IDX_W+1)'(WINDOW));
    end else begin
      ins_slot = IDX_W'(slot_sum);
    end
    if (exp == {SEQ_W{1'b1}} || exp_slot == IDX_W'(WINDOW - 1)) begin
      nslot = '0;
    end else begin
      nslot = exp_slot + 1'b1;
    end
    next_filled = filled[nslot] && (nslot != exp_slot);
    cur_len     = slen[exp_slot];
    is_dir      = (exp == SEQ_W'(0)) && !dir_seen;
    is_fn       = (exp == SEQ_W'(1)) && !fn_seen;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    emit       = 1'b0;
    k          = K_ACK;
    o_seq      = cmd.seq;
    o_len      = '0;
    o_slot     = '0;
    o_status   = ST_IN_ORDER;
    o_csum     = '0;
    o_last     = 1'b1;
    ins_we     = 1'b0;
    advance    = 1'b0;
    set_dir    = 1'b0;
    set_fn     = 1'b0;
    set_done   = 1'b0;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          pop    = 1'b1;
          emit   = 1'b1;
          o_csum = cmd.reply_csum;
          if (!cmd.ok) begin
            k = K_NAK;
          end else if (in_win) begin
            ins_we = 1'b1;
            o_slot = SLOT_W'(ins_slot);
            if (cmd.seq == exp) begin
              o_last     = 1'b0;
              state_next = S_WALK;
            end else begin
              o_status = ST_OUT_OF_ORDER;
            end
          end else begin
            o_status = ST_IGNORED;
          end
        end
      end
      S_WALK: begin
        emit   = 1'b1;
        o_seq  = exp;
        o_slot = SLOT_W'(exp_slot);
        o_len  = cur_len;
        if (is_dir) begin
          k       = K_DIR;
          set_dir = 1'b1;
          advance = 1'b1;
        end else if (is_fn && cur_len == '0) begin
          k        = K_EMPTY_FN;
          set_done = 1'b1;
        end else if (is_fn) begin
          k       = K_FILENAME;
          set_fn  = 1'b1;
          advance = 1'b1;
        end else if (cur_len == '0) begin
          k        = K_EOF;
          set_done = 1'b1;
        end else begin
          k       = K_DATA;
          advance = 1'b1;
        end
        if (advance) begin
          o_last     = !next_filled;
          state_next = next_filled ? S_WALK : S_IDLE;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exp      <= '0;
      exp_slot <= '0;
      dir_seen <= 1'b0;
      fn_seen  <= 1'b0;
      done     <= 1'b0;
      strobe   <= 1'b0;
      for (int i = 0; i < WINDOW; i++) begin
        filled[i] <= 1'b0;
      end
    end else begin
      strobe <= emit;
      if (ins_we) begin
        filled[ins_slot] <= 1'b1;
      end
      if (advance) begin
        filled[exp_slot] <= 1'b0;
        exp              <= exp + 1'b1;
        exp_slot         <= nslot;
      end
      if (set_dir) begin
        dir_seen <= 1'b1;
      end
      if (set_fn) begin
        fn_seen <= 1'b1;
      end
      if (set_done) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ins_we) begin
      slen[ins_slot] <= cmd.sat_len;
    end
    kind           <= k;
    out_seq        <= o_seq;
    out_length     <= o_len;
    slot           <= o_slot;
    arrival_status <= o_status;
    reply_checksum <= o_csum;
    last           <= o_last;
  end

  a_pop_gives_result: assert property (@(posedge clk) disable iff (rst)
    pop |=> strobe)
    else $error("popped command produced no result");

  a_results_contiguous: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> strobe)
    else $error("gap inside one transaction's results");

  a_walk_slot_filled: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> filled[exp_slot])
    else $error("release walk on an empty slot");

  a_release_from_walk: assert property (@(posedge clk) disable iff (rst)
    (strobe && kind != K_ACK && kind != K_NAK) |-> $past(state == S_WALK))
    else $error("release emitted outside the walk");

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    done |=> done)
    else $error("transfer done flag cleared");

endmodule

FILE: sim/tb_selective_repeat_receiver.sv
`timescale 1ns / 1ps
// Self-checking testbench for the selective repeat receiver: table, in-order run, random.
module tb_selective_repeat_receiver;
  import srr_pkg::*;

  localparam int          HOLD_LIMIT   = 2000;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          RANDOM_ITEMS = 76;
  localparam int          CALM_ITEMS   = 20;
  localparam int          RUN_ITEMS    = 8;

  typedef struct {
    logic [2:0]  kind;
    logic [15:0] seq;
    logic [10:0] len;
    logic [3:0]  slot;
    logic [1:0]  status;
    logic [15:0] csum;
    logic        last;
  } reply_t;

  typedef struct {
    logic [15:0] seq;
    logic [15:0] ackf;
    logic [15:0] dlen;
    logic [17:0] psum;
    bit          corrupt;
    bit          typed;
    logic [2:0]  kind;
    logic [1:0]  status;
  } header_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [15:0] seq_num;
  logic [15:0] ack_field;
  logic [15:0] pkt_length;
  logic [15:0] checksum_received;
  logic [17:0] payload_sum;
  logic        strobe;
  logic [2:0]  kind;
  logic [15:0] out_seq;
  logic [10:0] out_length;
  logic [3:0]  slot;
  logic [1:0]  arrival_status;
  logic [15:0] reply_checksum;
  logic        last;

  // receiver state as seen by the testbench
  logic [15:0]     next_seq;
  bit [WINDOW-1:0] held;
  logic [10:0]     held_len [WINDOW];
  bit              dir_done;
  bit              name_done;
  bit              xfer_done;

  reply_t      pending [$];
  header_row_t plan [$];
  bit          failed;
  bit          empty_run;
  logic        row_typed;
  logic [2:0]  row_kind;
  logic [1:0]  row_status;
  int          mark;
  int          idle_cycles;
  reply_t      want;

  selective_repeat_receiver dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .seq_num          (seq_num),
    .ack_field        (ack_field),
    .pkt_length       (pkt_length),
    .checksum_received(checksum_received),
    .payload_sum      (payload_sum),
    .strobe           (strobe),
    .kind             (kind),
    .out_seq          (out_seq),
    .out_length       (out_length),
    .slot             (slot),
    .arrival_status   (arrival_status),
    .reply_checksum   (reply_checksum),
    .last             (last)
  );

  always #2 clk = ~clk;

  function automatic logic [15:0] sum_complement(logic [31:0] s);
    while (s[31:16] != 16'd0) s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
    return ~s[15:0];
  endfunction

  function automatic void push_reply(logic [2:0] k, logic [15:0] sq, logic [10:0] ln,
                                     logic [3:0] sl, logic [1:0] st, logic [15:0] cs);
    reply_t r;
    r.kind   = k;
    r.seq    = sq;
    r.len    = ln;
    r.slot   = sl;
    r.status = st;
    r.csum   = cs;
    r.last   = 1'b0;
    pending.push_back(r);
  endfunction

  // ack/nak plus in-order release walk for one header
  function automatic void receive_header(logic [15:0] sq, logic [15:0] ackf, logic [15:0] dlen,
                                         logic [15:0] cs, logic [17:0] ps);
    int         s;
    logic [10:0] ln;
    if (sum_complement(32'(sq) + 32'(ackf) + 32'(dlen) + 32'(ps)) != cs) begin
      push_reply(K_NAK, sq, 11'd0, 4'd0, ST_IN_ORDER, sum_complement(32'(sq) + 32'd2));
    end else if (!xfer_done && sq >= next_seq && 32'(sq) < 32'(next_seq) + WINDOW) begin
      s = sq % WINDOW;
      held[s] = 1'b1;
      held_len[s] = (dlen > MAX_PAYLOAD) ? 11'(MAX_PAYLOAD) : dlen[10:0];
      push_reply(K_ACK, sq, 11'd0, 4'(s), (sq == next_seq) ? ST_IN_ORDER : ST_OUT_OF_ORDER,
                 sum_complement(32'(sq) + 32'd1));
      for (int i = 0; i < WINDOW; i++) begin
        s = next_seq % WINDOW;
        if (!held[s]) break;
        ln = held_len[s];
        if (next_seq == 16'd0 && !dir_done) begin
          dir_done = 1'b1;
          push_reply(K_DIR, next_seq, ln, 4'(s), ST_IN_ORDER, 16'd0);
        end else if (next_seq == 16'd1 && !name_done) begin
          if (ln == 11'd0) begin
            push_reply(K_EMPTY_FN, next_seq, 11'd0, 4'(s), ST_IN_ORDER, 16'd0);
            xfer_done = 1'b1;
            break;
          end
          name_done = 1'b1;
          push_reply(K_FILENAME, next_seq, ln, 4'(s), ST_IN_ORDER, 16'd0);
        end else if (ln == 11'd0) begin
          // end of file stays in its slot
          push_reply(K_EOF, next_seq, 11'd0, 4'(s), ST_IN_ORDER, 16'd0);
          xfer_done = 1'b1;
          break;
        end else begin
          push_reply(K_DATA, next_seq, ln, 4'(s), ST_IN_ORDER, 16'd0);
        end
        held[s] = 1'b0;
        next_seq = next_seq + 16'd1;
      end
    end else begin
      push_reply(K_ACK, sq, 11'd0, 4'd0, ST_IGNORED, sum_complement(32'(sq) + 32'd1));
    end
    pending[pending.size() - 1].last = 1'b1;
  endfunction

  function automatic void compare_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want_v, got_v);
      failed = 1'b1;
    end
  endfunction

  function automatic void add_row(logic [15:0] sq, logic [15:0] ackf, logic [15:0] dlen,
                                  logic [17:0] ps, bit corrupt, bit typed,
                                  logic [2:0] k, logic [1:0] st);
    header_row_t r;
    r.seq     = sq;
    r.ackf    = ackf;
    r.dlen    = dlen;
    r.psum    = ps;
    r.corrupt = corrupt;
    r.typed   = typed;
    r.kind    = k;
    r.status  = st;
    plan.push_back(r);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (start === 1'b1 && busy === 1'b0) begin
        mark = pending.size();
        receive_header(seq_num, ack_field, pkt_length, checksum_received, payload_sum);
        if (row_typed && (pending[mark].kind != row_kind || pending[mark].status != row_status)) begin
          $display("%0t: header seq %0d reply, expected kind %0d status %0d actual %0d %0d",
                   $time, seq_num, row_kind, row_status, pending[mark].kind,
                   pending[mark].status);
          failed = 1'b1;
        end
      end
      if (strobe === 1'b1) begin
        if (pending.size() == 0) begin
          $display("%0t: unexpected result, expected none actual kind %0d seq %0d",
                   $time, kind, out_seq);
          failed = 1'b1;
        end else begin
          want = pending.pop_front();
          compare_field("kind", 16'(want.kind), 16'(kind));
          compare_field("out_seq", want.seq, out_seq);
          compare_field("out_length", 16'(want.len), 16'(out_length));
          compare_field("slot", 16'(want.slot), 16'(slot));
          compare_field("arrival_status", 16'(want.status), 16'(arrival_status));
          compare_field("reply_checksum", want.csum, reply_checksum);
          compare_field("last", 16'(want.last), 16'(last));
        end
      end
      if ((start === 1'b1 && busy === 1'b0) || strobe === 1'b1) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= HOLD_LIMIT) begin
        $display("selective_repeat_receiver verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the header is taken
  task automatic send_header(logic [15:0] sq, logic [15:0] ackf, logic [15:0] dlen,
                             logic [17:0] ps, bit corrupt, bit typed,
                             logic [2:0] k, logic [1:0] st);
    logic [15:0] cs;
    cs = sum_complement(32'(sq) + 32'(ackf) + 32'(dlen) + 32'(ps));
    if (corrupt) cs = cs ^ 16'($urandom_range(1, 65535));
    seq_num           = sq;
    ack_field         = ackf;
    pkt_length        = dlen;
    checksum_received = cs;
    payload_sum       = ps;
    row_typed         = typed;
    row_kind          = k;
    row_status        = st;
    start             = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  task automatic idle_sender(int n);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain_wait();
    start = 1'b0;
    while (pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic [15:0] sq;
    logic [15:0] dlen;
    int          pick;
    rst               = 1'b1;
    start             = 1'b0;
    seq_num           = 16'd0;
    ack_field         = 16'd0;
    pkt_length        = 16'd0;
    checksum_received = 16'd0;
    payload_sum       = 18'd0;
    row_typed         = 1'b0;
    row_kind          = K_ACK;
    row_status        = ST_IN_ORDER;
    next_seq          = 16'd0;
    held              = '0;
    dir_done          = 1'b0;
    name_done         = 1'b0;
    xfer_done         = 1'b0;
    failed            = 1'b0;
    // now and then the filename comes empty and the transfer ends early
    empty_run = ($urandom_range(0, 7) == 0);

    add_row(16'd5, 16'd0, 16'd100, 18'd1000, 0, 1, K_ACK, ST_OUT_OF_ORDER);
    add_row(16'd0, 16'hFFFF, 16'hFFFF, 18'd261120, 1, 1, K_NAK, ST_IN_ORDER);
    add_row(16'd10, 16'd0, 16'd1, 18'd0, 0, 1, K_ACK, ST_IGNORED);
    add_row(16'hFFFF, 16'hFFFF, 16'd1, 18'd5, 0, 1, K_ACK, ST_IGNORED);
    add_row(16'd1, 16'hFFFF, empty_run ? 16'd0 : 16'hFFFF, 18'd261120, 0, 1,
            K_ACK, ST_OUT_OF_ORDER);
    add_row(16'd0, 16'h1234, 16'd0, 18'd0, 0, 1, K_ACK, ST_IN_ORDER);
    add_row(16'd3, 16'h8000, 16'd1025, 18'd131072, 0, 0, K_ACK, ST_IN_ORDER);
    add_row(16'd2, 16'd7, 16'd7, 18'd700, 0, 0, K_ACK, ST_IN_ORDER);
    add_row(16'd5, 16'd0, 16'd9, 18'd900, 0, 0, K_ACK, ST_IN_ORDER);
    add_row(16'd9, 16'h5555, 16'd1024, 18'd65535, 0, 0, K_ACK, ST_IN_ORDER);
    add_row(16'd4, 16'haaaa, 16'd1, 18'd255, 0, 0, K_ACK, ST_IN_ORDER);
    add_row(16'd7, 16'd0, 16'd513, 18'd3, 0, 0, K_ACK, ST_IN_ORDER);
    add_row(16'd8, 16'd0, 16'd1023, 18'd4, 0, 0, K_ACK, ST_IN_ORDER);
    add_row(16'd6, 16'd0, 16'd2, 18'd9, 0, 0, K_ACK, ST_IN_ORDER);
    add_row(16'd9, 16'd1, 16'd3, 18'd6, 0, 0, K_ACK, ST_IN_ORDER);
    add_row(16'haaaa, 16'h5555, 16'h7FFF, 18'h2AAAA, 1, 1, K_NAK, ST_IN_ORDER);
    // fill a whole window backwards, then one header releases all of it
    for (int i = 19; i >= 10; i--)
      add_row(16'(i), 16'(i * 97), 16'(i * 50), 18'(i * 1000), 0, 0, K_ACK, ST_IN_ORDER);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      send_header(plan[i].seq, plan[i].ackf, plan[i].dlen, plan[i].psum, plan[i].corrupt,
                  plan[i].typed, plan[i].kind, plan[i].status);
      if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 10));
    end
    drain_wait();

    // short in-order run
    for (int i = 0; i < RUN_ITEMS && !xfer_done; i++)
      send_header(next_seq, 16'($urandom), 16'($urandom_range(1, 1024)),
                  18'($urandom_range(0, 261120)), 0, 0, K_ACK, ST_IN_ORDER);
    drain_wait();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) dlen = 16'($urandom_range(1025, 65535));
      else if (i >= RANDOM_ITEMS / 2 && $urandom_range(0, 24) == 0) dlen = 16'd0;
      else dlen = 16'($urandom_range(1, 1024));
      if (pick < 25) sq = 16'($urandom);
      else sq = next_seq + 16'($urandom_range(0, WINDOW + 1));
      send_header(sq, 16'($urandom), (pick < 15) ? 16'($urandom) : dlen,
                  18'($urandom_range(0, 261120)), pick < 15, 0, K_ACK, ST_IN_ORDER);
      if (i == RANDOM_ITEMS / 3) drain_wait();
      if (i < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0)
        idle_sender($urandom_range(1, 10));
    end

    drain_wait();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (failed) begin
      $display("selective_repeat_receiver verification failed");
    end else begin
      $display("selective_repeat_receiver verification clean");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/srr_pkg.sv
hdl/srr_front.sv
hdl/srr_queue.sv
hdl/srr_back.sv
hdl/selective_repeat_receiver.sv
sim/tb_selective_repeat_receiver.sv
